// ===== design/idll_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed doubly linked list package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package idll_pkg;

  localparam int unsigned IdW       = 10;
  localparam int unsigned NodeCount = 1 << IdW;

  typedef logic [IdW-1:0] id_t;

  localparam id_t NullId  = '0;
  localparam id_t FirstId = id_t'(1);

  typedef enum logic [1:0] {
    OP_INS_BEFORE = 2'd0,
    OP_INS_AFTER  = 2'd1,
    OP_REMOVE     = 2'd2,
    OP_WALK       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef struct packed {
    logic clear;
    logic accept;
    logic look;
    logic eval;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

endpackage

// ===== design/indexed_doubly_linked_list.sv =====
// ----------------------------------------------------------------------------
// Indexed doubly linked list
// Ordered list of node ids kept in previous/next link tables with presence
// bits and a head register; supports insert before/after, remove and walk.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over its tables, with in_ready_o
// low, and then holds node 1 as the only member. Each item then takes its
// steps in order, and a new item is accepted only once the previous one has
// finished them: the accepting step reads the reference entry, the lookup step
// reads the new or walked-to entry, and two write steps follow, since each link
// table has a single read and a single write port. The result register is
// loaded in the second write step. The result sits in an output register, so
// the next item is accepted while the previous result waits; an item stalls
// only when its own result is ready and the previous one has not been taken.
module indexed_doubly_linked_list import idll_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  id_t        new_id_i,
  input  id_t        ref_id_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output id_t        node_id_o,
  output logic       is_last_o,
  output logic       list_empty_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  idll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  idll_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (op_i),
    .new_id_i     (new_id_i),
    .ref_id_i     (ref_id_i),
    .status_o     (status_o),
    .node_id_o    (node_id_o),
    .is_last_o    (is_last_o),
    .list_empty_o (list_empty_o)
  );

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clear, cmd.accept, cmd.look, cmd.eval, cmd.fin}))
    else $error("More than one datapath command is active.");

  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> cmd.look && cmd.eval == 1'b0)
    else $error("An accepted item did not go to the lookup step.");

  a_look_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.look |=> cmd.eval)
    else $error("The lookup step was not followed by evaluation.");

  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |=> out_valid_o && !in_ready_o == 1'b0)
    else $error("A finished item did not present its result.");

endmodule

// ===== design/idll_ctrl.sv =====
// ----------------------------------------------------------------------------
// Indexed doubly linked list controller
// Sequences the clearing pass and the four steps of each item, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module idll_ctrl import idll_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.fin) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/idll_datapath.sv =====
// ----------------------------------------------------------------------------
// Indexed doubly linked list datapath
// Link tables, presence table, head register, item registers and result
// registers, with the write selection for each step of an item.
// ----------------------------------------------------------------------------
module idll_datapath import idll_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  logic [1:0]  op_i,
  input  id_t         new_id_i,
  input  id_t         ref_id_i,
  output logic [1:0]  status_o,
  output id_t         node_id_o,
  output logic        is_last_o,
  output logic        list_empty_o
);

  logic present_mem [NodeCount];
  id_t  prev_mem    [NodeCount];
  id_t  next_mem    [NodeCount];

  id_t     clr_cnt_q;
  id_t     head_q, head_d;
  op_e     op_q;
  id_t     nid_q, ref_q;
  logic    ref_ok_q;
  id_t     prev_ref_q, next_ref_q;
  id_t     node_q, node_d;
  status_e status_q, status_d;
  logic    last_q, last_d;

  logic    pres_rd_q;
  id_t     prev_rd_q, next_rd_q;

  logic    pres_we, pres_wdata;
  id_t     pres_waddr, pres_raddr;
  logic    prev_we;
  id_t     prev_waddr, prev_wdata;
  logic    next_we;
  id_t     next_waddr, next_wdata, next_raddr;

  logic    is_ins, is_before, eval_ok, fin_ok;
  id_t     nb;

  logic [1:0] status_out_q;
  id_t        node_out_q;
  logic       last_out_q, empty_out_q;

  assign is_ins    = (op_q == OP_INS_BEFORE) || (op_q == OP_INS_AFTER);
  assign is_before = (op_q == OP_INS_BEFORE);
  assign nb        = is_before ? prev_ref_q : next_ref_q;

  always_comb begin
    if (op_q != OP_WALK) begin
      node_d = NullId;
    end else if (ref_q == NullId) begin
      node_d = head_q;
    end else if (pres_rd_q) begin
      node_d = next_rd_q;
    end else begin
      node_d = NullId;
    end
  end

  always_comb begin
    case (op_q)
      OP_INS_BEFORE, OP_INS_AFTER: begin
        status_d = (nid_q == NullId || pres_rd_q || !ref_ok_q) ? ST_REJECT : ST_DONE;
      end
      OP_REMOVE: begin
        status_d = ref_ok_q ? ST_DONE : ST_ABSENT;
      end
      default: begin
        status_d = (ref_q != NullId && !ref_ok_q) ? ST_ABSENT : ST_DONE;
      end
    endcase
  end

  assign last_d  = (node_q != NullId) && (next_rd_q == NullId);
  assign eval_ok = cmd_i.eval && (status_d == ST_DONE);
  assign fin_ok  = cmd_i.fin && (status_q == ST_DONE) && is_ins;

  assign pres_raddr = cmd_i.look ? nid_q : ref_id_i;
  assign next_raddr = cmd_i.look ? node_d : ref_id_i;

  always_comb begin
    pres_we    = 1'b0;
    pres_waddr = nid_q;
    pres_wdata = 1'b1;
    prev_we    = 1'b0;
    prev_waddr = nid_q;
    prev_wdata = NullId;
    next_we    = 1'b0;
    next_waddr = nid_q;
    next_wdata = NullId;
    head_d     = head_q;
    if (cmd_i.clear) begin
      pres_we    = 1'b1;
      pres_waddr = clr_cnt_q;
      pres_wdata = (clr_cnt_q == FirstId);
      prev_we    = 1'b1;
      prev_waddr = clr_cnt_q;
      next_we    = 1'b1;
      next_waddr = clr_cnt_q;
    end else if (eval_ok && is_ins) begin
      pres_we    = 1'b1;
      prev_we    = 1'b1;
      prev_wdata = is_before ? prev_ref_q : ref_q;
      next_we    = 1'b1;
      next_wdata = is_before ? ref_q : next_ref_q;
    end else if (eval_ok && op_q == OP_REMOVE) begin
      pres_we    = 1'b1;
      pres_waddr = ref_q;
      pres_wdata = 1'b0;
      prev_we    = (next_ref_q != NullId);
      prev_waddr = next_ref_q;
      prev_wdata = prev_ref_q;
      next_we    = (prev_ref_q != NullId);
      next_waddr = prev_ref_q;
      next_wdata = next_ref_q;
      if (prev_ref_q == NullId) begin
        head_d = next_ref_q;
      end
    end else if (fin_ok) begin
      prev_wdata = nid_q;
      next_wdata = nid_q;
      if (is_before) begin
        prev_we    = 1'b1;
        prev_waddr = ref_q;
        next_we    = (nb != NullId);
        next_waddr = nb;
        if (nb == NullId) begin
          head_d = nid_q;
        end
      end else begin
        next_we    = 1'b1;
        next_waddr = ref_q;
        prev_we    = (nb != NullId);
        prev_waddr = nb;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pres_we) begin
      present_mem[pres_waddr] <= pres_wdata;
    end
    pres_rd_q <= present_mem[pres_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    prev_rd_q <= prev_mem[ref_id_i];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rd_q <= next_mem[next_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= NullId;
      head_q    <= FirstId;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + id_t'(1);
      end
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_e'(op_i);
      nid_q <= new_id_i;
      ref_q <= ref_id_i;
    end
    if (cmd_i.look) begin
      ref_ok_q   <= pres_rd_q;
      prev_ref_q <= prev_rd_q;
      next_ref_q <= next_rd_q;
      node_q     <= node_d;
    end
    if (cmd_i.eval) begin
      status_q <= status_d;
      last_q   <= last_d;
    end
    if (cmd_i.fin) begin
      status_out_q <= status_q;
      node_out_q   <= node_q;
      last_out_q   <= last_q;
      empty_out_q  <= (head_d == NullId);
    end
  end

  assign stat_o.clear_last = &clr_cnt_q;

  assign status_o     = status_out_q;
  assign node_id_o    = node_out_q;
  assign is_last_o    = last_out_q;
  assign list_empty_o = empty_out_q;

endmodule

// ===== tb/indexed_doubly_linked_list_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed doubly linked list testbench
// Drives insert, remove and walk items through the valid/ready input channel
// and compares every result against a local model of the link tables. Both
// channels idle at random, and the receiver holds off once long enough to
// stall the input.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list_test;
  import idll_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned MaxMembers    = 64;
  localparam id_t         LastId        = id_t'(NodeCount - 1);

  typedef struct packed {
    status_e status;
    id_t     node;
    logic    last;
    logic    empty;
  } list_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] op_i;
  logic [9:0] new_id_i;
  logic [9:0] ref_id_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] status_o;
  logic [9:0] node_id_o;
  logic       is_last_o;
  logic       list_empty_o;

  id_t          prev_link [NodeCount];
  id_t          next_link [NodeCount];
  bit           member    [NodeCount];
  id_t          head_id;
  id_t          member_ids[$];
  list_result_t pending_results[$];

  int unsigned error_count = 0;
  bit          idle_enable = 1'b1;
  bit          hold_output = 1'b0;

  indexed_doubly_linked_list u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .new_id_i    (new_id_i),
    .ref_id_i    (ref_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .node_id_o   (node_id_o),
    .is_last_o   (is_last_o),
    .list_empty_o(list_empty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enable || r < 50) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  function automatic void reset_list_model();
    for (int i = 0; i < NodeCount; i++) begin
      prev_link[i] = NullId;
      next_link[i] = NullId;
      member[i]    = 1'b0;
    end
    member[FirstId] = 1'b1;
    head_id         = FirstId;
    member_ids      = '{FirstId};
  endfunction

  function automatic void drop_member_id(id_t id);
    for (int i = 0; i < member_ids.size(); i++) begin
      if (member_ids[i] == id) begin
        member_ids.delete(i);
        return;
      end
    end
  endfunction

  function automatic list_result_t apply_list_op(op_e op, id_t nid, id_t rid);
    list_result_t r;
    id_t          nb;
    id_t          pv;
    r = '{status: ST_DONE, node: NullId, last: 1'b0, empty: 1'b0};
    case (op)
      OP_INS_BEFORE, OP_INS_AFTER: begin
        if (nid == NullId || member[nid] || rid == NullId || !member[rid]) begin
          r.status = ST_REJECT;
        end else if (op == OP_INS_BEFORE) begin
          nb             = prev_link[rid];
          prev_link[nid] = nb;
          next_link[nid] = rid;
          prev_link[rid] = nid;
          if (nb == NullId) begin
            head_id = nid;
          end else begin
            next_link[nb] = nid;
          end
        end else begin
          nb             = next_link[rid];
          prev_link[nid] = rid;
          next_link[nid] = nb;
          next_link[rid] = nid;
          if (nb != NullId) begin
            prev_link[nb] = nid;
          end
        end
        if (r.status == ST_DONE) begin
          member[nid] = 1'b1;
          member_ids.push_back(nid);
        end
      end
      OP_REMOVE: begin
        if (rid == NullId || !member[rid]) begin
          r.status = ST_ABSENT;
        end else begin
          pv = prev_link[rid];
          nb = next_link[rid];
          if (pv == NullId) begin
            head_id = nb;
          end else begin
            next_link[pv] = nb;
          end
          if (nb != NullId) begin
            prev_link[nb] = pv;
          end
          prev_link[rid] = NullId;
          next_link[rid] = NullId;
          member[rid]    = 1'b0;
          drop_member_id(rid);
        end
      end
      default: begin
        if (rid == NullId) begin
          r.node = head_id;
        end else if (member[rid]) begin
          r.node = next_link[rid];
        end else begin
          r.status = ST_ABSENT;
        end
        r.last = (r.node != NullId) && member[r.node] && (next_link[r.node] == NullId);
      end
    endcase
    r.empty = (head_id == NullId);
    return r;
  endfunction

  task automatic send_item(op_e op, id_t nid, id_t rid);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    new_id_i   <= nid;
    ref_id_i   <= rid;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_list_op(op, nid, rid));
  endtask

  function automatic id_t pick_member();
    if (member_ids.size() == 0) begin
      return NullId;
    end
    return member_ids[$urandom_range(0, member_ids.size() - 1)];
  endfunction

  task automatic test_walk_after_reset();
    send_item(OP_WALK, NullId, NullId);
    send_item(OP_WALK, LastId, FirstId);
    send_item(OP_WALK, NullId, id_t'(5));
  endtask

  task automatic test_insert();
    send_item(OP_INS_BEFORE, LastId, FirstId);
    send_item(OP_INS_AFTER, id_t'(2), FirstId);
    send_item(OP_INS_AFTER, id_t'(512), id_t'(2));
    send_item(OP_INS_BEFORE, id_t'(3), id_t'(2));
    send_item(OP_INS_AFTER, NullId, FirstId);
    send_item(OP_INS_BEFORE, id_t'(2), id_t'(512));
    send_item(OP_INS_AFTER, id_t'(7), NullId);
    send_item(OP_INS_BEFORE, id_t'(7), id_t'(700));
    send_item(OP_WALK, NullId, NullId);
    send_item(OP_WALK, NullId, LastId);
    send_item(OP_WALK, NullId, id_t'(3));
  endtask

  task automatic test_remove();
    send_item(OP_REMOVE, NullId, NullId);
    send_item(OP_REMOVE, NullId, id_t'(700));
    send_item(OP_REMOVE, NullId, LastId);
    send_item(OP_INS_BEFORE, id_t'(9), FirstId);
    send_item(OP_WALK, NullId, NullId);
    send_item(OP_REMOVE, NullId, id_t'(512));
    send_item(OP_REMOVE, NullId, id_t'(3));
    send_item(OP_WALK, NullId, id_t'(2));
  endtask

  task automatic test_output_backpressure();
    idle_enable = 1'b0;
    hold_output = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_item(OP_WALK, NullId, (i % 2 == 0) ? NullId : pick_member());
    end
    wait (!hold_output);
    idle_enable = 1'b1;
  endtask

  task automatic test_random_ops(int unsigned count);
    int  r;
    op_e op;
    id_t nid;
    id_t rid;
    for (int unsigned i = 0; i < count; i++) begin
      idle_enable = (i % 250) >= 60;
      r   = $urandom_range(0, 99);
      nid = id_t'($urandom_range(1, NodeCount - 1));
      rid = pick_member();
      if (r < 10) begin
        nid = NullId;
      end else if (r < 18) begin
        nid = pick_member();
      end
      r = $urandom_range(0, 99);
      if (r < 40 && member_ids.size() < MaxMembers) begin
        op = ($urandom_range(0, 1) != 0) ? OP_INS_AFTER : OP_INS_BEFORE;
        if ($urandom_range(0, 9) == 0) begin
          rid = id_t'($urandom_range(0, NodeCount - 1));
        end
      end else if (r < 60) begin
        op = (member_ids.size() > 1) ? OP_REMOVE : OP_WALK;
      end else if (r < 85) begin
        op = OP_WALK;
        if ($urandom_range(0, 3) == 0) begin
          rid = NullId;
        end
      end else begin
        op  = op_e'($urandom_range(0, 3));
        nid = id_t'($urandom_range(0, NodeCount - 1));
        rid = id_t'($urandom_range(0, NodeCount - 1));
        if (op == OP_REMOVE && member_ids.size() <= 1) begin
          op = OP_WALK;
        end
      end
      send_item(op, nid, rid);
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_empty_list();
    while (member_ids.size() > 1) begin
      send_item(OP_REMOVE, NullId, member_ids[member_ids.size() - 1]);
    end
    send_item(OP_WALK, NullId, NullId);
    send_item(OP_REMOVE, NullId, member_ids[0]);
    send_item(OP_WALK, NullId, NullId);
    send_item(OP_WALK, NullId, LastId);
    send_item(OP_INS_BEFORE, id_t'(5), NullId);
    send_item(OP_INS_AFTER, id_t'(5), FirstId);
    send_item(OP_REMOVE, NullId, FirstId);
  endtask

  initial begin : receiver
    int n;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_output = 1'b0;
      end else begin
        n = pick_gap();
        if (n == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          repeat (n - 1) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    list_result_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d node_id %0d", status_o, node_id_o);
        error_count++;
      end else begin
        exp = pending_results.pop_front();
        if (status_o !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, status_o);
          error_count++;
        end
        if (node_id_o !== exp.node) begin
          $error("node_id: expected %0d, got %0d", exp.node, node_id_o);
          error_count++;
        end
        if (is_last_o !== exp.last) begin
          $error("is_last: expected %0d, got %0d", exp.last, is_last_o);
          error_count++;
        end
        if (list_empty_o !== exp.empty) begin
          $error("list_empty: expected %0d, got %0d", exp.empty, list_empty_o);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("indexed_doubly_linked_list regression: fail");
    $finish;
  end

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    op_i       <= OP_WALK;
    new_id_i   <= NullId;
    ref_id_i   <= NullId;
    reset_list_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_walk_after_reset();
    test_insert();
    test_remove();
    test_output_backpressure();
    test_random_ops(1250);
    test_empty_list();

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("indexed_doubly_linked_list regression: pass");
    end else begin
      $display("indexed_doubly_linked_list regression: fail");
    end
    $finish;
  end

endmodule

// ===== indexed_doubly_linked_list.f =====
design/idll_pkg.sv
design/idll_ctrl.sv
design/idll_datapath.sv
design/indexed_doubly_linked_list.sv
tb/indexed_doubly_linked_list_test.sv
